/* rtl/core/rari_pkg.sv */
// shared codes and helpers for the ray against axis-aligned rectangle test
`default_nettype none

package rari_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLANE_AXIS  = 3'd0,
        CFG_PLANE_POS   = 3'd1,
        CFG_SPAN_A_LOW  = 3'd2,
        CFG_SPAN_A_HIGH = 3'd3,
        CFG_SPAN_B_LOW  = 3'd4,
        CFG_SPAN_B_HIGH = 3'd5
    } cfg_idx_t;

    // rectangle orientation codes
    typedef enum logic [1:0] {
        AXIS_XY   = 2'd0,
        AXIS_XZ   = 2'd1,
        AXIS_YZ   = 2'd2,
        AXIS_NONE = 2'd3
    } axis_t;

    // coordinate slots: normal axis and the two in-plane axes
    typedef struct packed {
        logic       ok;
        logic [1:0] n;
        logic [1:0] a;
        logic [1:0] b;
    } axis_sel_t;

    function automatic axis_sel_t axis_select(input logic [1:0] code);
        axis_sel_t s;
        s = '{ok: 1'b0, n: 2'd0, a: 2'd0, b: 2'd0};
        case (axis_t'(code))
            AXIS_XY: s = '{ok: 1'b1, n: 2'd2, a: 2'd0, b: 2'd1};
            AXIS_XZ: s = '{ok: 1'b1, n: 2'd1, a: 2'd0, b: 2'd2};
            AXIS_YZ: s = '{ok: 1'b1, n: 2'd0, a: 2'd1, b: 2'd2};
            default: s = '{ok: 1'b0, n: 2'd0, a: 2'd0, b: 2'd0};
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ray_axis_rect_intersect_top.sv */
// Ray against axis-aligned rectangle intersection, fully pipelined
//
// Input stream: one ray per transaction on s_tvalid/s_tready/s_tdata.
// Output stream: one result per ray on m_tvalid/m_tready/m_tdata/m_tuser,
// in the same order. m_tuser carries the hit and front-face flags; on a
// miss every other field is zero.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data selects
// and writes a rectangle register; cfg_ready is always high. The user must
// change registers only while no ray is in flight; the block does not enforce it.
// Throughput is one ray per clock while the receiver takes results. The
// pipeline holds a pipelined restoring divider for t (one quotient bit per
// stage) followed by the u,v dividers.
// Reset clears all valid bits and loads the default unit square in the XY
// plane at offset zero.
// When the receiver stalls with a result waiting, the whole pipeline holds;
// nothing is dropped or repeated and s_tready falls until it drains.
`default_nettype none

module ray_axis_rect_intersect_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // ray in: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_lower, t_upper
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [8*COORD_WIDTH-1:0]            s_tdata,
    // result: hit_t, hit_x, hit_y, hit_z, tex_u, tex_v, zero fill
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((4*COORD_WIDTH+2*FRAC_BITS+2+7)/8)*8-1:0] m_tdata,
    // result flags: hit, front_face
    output logic [1:0]                          m_tuser,
    // config write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rari_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [COORD_WIDTH-1:0]              cfg_data
);
    import rari_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int TW  = W + F + 1;
    localparam int XW  = TW + W;
    localparam int PW  = (XW > 64) ? 64 : XW;
    localparam int SW  = PW - F;
    localparam int PPW = ((SW > W) ? SW : W) + 1;
    localparam int L   = TW / 2;
    localparam int HW  = TW - L;
    localparam int UW  = F + 1;
    localparam int ODW = ((4*W + 2*UW + 7) / 8) * 8;
    localparam logic [W-1:0] ONE_FX = W'(1) << F;
    localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [2:0][W-1:0] o;
        logic [2:0][W-1:0] d;
        logic [W-1:0]      tlo;
        logic [W-1:0]      thi;
    } ray_t;

    typedef struct packed {
        ray_t          ray;
        logic [W-1:0]  den;
        logic [W-1:0]  rem;
        logic [TW-1:0] num;
        logic [TW-1:0] quo;
        logic          neg;
        logic          ff;
        logic          miss;
    } tdiv_t;

    typedef struct packed {
        logic [2:0][W-1:0] o;
        logic [2:0][W-1:0] d;
        logic [W-1:0]      tlo;
        logic [W-1:0]      thi;
        logic [TW-1:0]     t;
        logic              ff;
        logic              miss;
    } tval_t;

    typedef struct packed {
        logic [2:0][W-1:0]    o;
        logic [2:0][HW+W-1:0] pph;
        logic [2:0][L+W:0]    ppl;
        logic [TW-1:0]        t;
        logic                 ff;
        logic                 miss;
    } mul_t;

    typedef struct packed {
        logic [2:0][W-1:0]  o;
        logic [2:0][PW-1:0] prod;
        logic [TW-1:0]      t;
        logic               ff;
        logic               miss;
    } prod_t;

    typedef struct packed {
        logic [2:0][PPW-1:0] p;
        logic [TW-1:0]       t;
        logic                ff;
        logic                miss;
    } pnt_t;

    typedef struct packed {
        logic [W-1:0]      tsat;
        logic [2:0][W-1:0] psat;
        logic [W-1:0]      rema;
        logic [W-1:0]      wa;
        logic [UW-1:0]     qa;
        logic [W-1:0]      remb;
        logic [W-1:0]      wb;
        logic [UW-1:0]     qb;
        logic              za;
        logic              zb;
        logic              ff;
        logic              miss;
    } uv_t;

    // saturate wide signed values to the coordinate range
    function automatic logic [W-1:0] sat_t(input logic [TW-1:0] x);
        logic [W-1:0] r;
        r = x[W-1:0];
        if ($signed(x) > TW'(SMAX)) r = SMAX;
        if ($signed(x) < TW'(SMIN)) r = SMIN;
        return r;
    endfunction

    function automatic logic [W-1:0] sat_p(input logic [PPW-1:0] x);
        logic [W-1:0] r;
        r = x[W-1:0];
        if ($signed(x) > PPW'(SMAX)) r = SMAX;
        if ($signed(x) < PPW'(SMIN)) r = SMIN;
        return r;
    endfunction

    // configuration registers
    logic [1:0]   axis_reg;
    logic [W-1:0] pos_reg, alo_reg, ahi_reg, blo_reg, bhi_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg <= AXIS_XY;
            pos_reg  <= '0;
            alo_reg  <= '0;
            ahi_reg  <= ONE_FX;
            blo_reg  <= '0;
            bhi_reg  <= ONE_FX;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PLANE_AXIS:  axis_reg <= cfg_data[1:0];
                CFG_PLANE_POS:   pos_reg  <= cfg_data;
                CFG_SPAN_A_LOW:  alo_reg  <= cfg_data;
                CFG_SPAN_A_HIGH: ahi_reg  <= cfg_data;
                CFG_SPAN_B_LOW:  blo_reg  <= cfg_data;
                CFG_SPAN_B_HIGH: bhi_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: the whole pipe moves unless a result is stuck
    logic adv;
    logic out_v_reg;
    assign adv      = m_tready || !out_v_reg;
    assign s_tready = adv;

    axis_sel_t sel;
    assign sel = axis_select(axis_reg);

    // input register
    logic s0_v_reg;
    ray_t s0_reg, s0_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s0_next.o[k] = s_tdata[k*W +: W];
            s0_next.d[k] = s_tdata[(3+k)*W +: W];
        end
        s0_next.tlo = s_tdata[6*W +: W];
        s0_next.thi = s_tdata[7*W +: W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_v_reg <= 1'b0;
        else if (adv)
            s0_v_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s0_reg <= s0_next;
    end

    // divider setup: magnitudes and quotient sign
    logic              dv_v_reg [0:TW];
    tdiv_t             dv_reg   [0:TW];
    tdiv_t             dv0_next;
    logic signed [W:0] diff;
    logic [W-1:0]      on, dn, dmag, nmag;

    always_comb
    begin
        on   = s0_reg.o[sel.n];
        dn   = s0_reg.d[sel.n];
        diff = $signed({pos_reg[W-1], pos_reg}) - $signed({on[W-1], on});
        nmag = diff[W] ? W'(-diff) : diff[W-1:0];
        dmag = dn[W-1] ? W'(-$signed(dn)) : dn;
        dv0_next.ray  = s0_reg;
        dv0_next.den  = dmag;
        dv0_next.rem  = '0;
        dv0_next.num  = {1'b0, nmag, {F{1'b0}}};
        dv0_next.quo  = '0;
        dv0_next.neg  = diff[W] ^ dn[W-1];
        dv0_next.ff   = dn[W-1];
        dv0_next.miss = !sel.ok || (dn == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg[0] <= 1'b0;
        else if (adv)
            dv_v_reg[0] <= s0_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            dv_reg[0] <= dv0_next;
    end

    // restoring divider for t, one quotient bit per stage
    for (genvar i = 0; i < TW; i++)
    begin : g_tdiv
        tdiv_t      dv_next;
        logic [W:0] rr, sub;
        logic       ge;

        always_comb
        begin
            rr      = {dv_reg[i].rem, dv_reg[i].num[TW-1]};
            sub     = rr - {1'b0, dv_reg[i].den};
            ge      = rr >= {1'b0, dv_reg[i].den};
            dv_next = dv_reg[i];
            dv_next.rem = ge ? sub[W-1:0] : rr[W-1:0];
            dv_next.num = dv_reg[i].num << 1;
            dv_next.quo = {dv_reg[i].quo[TW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[i+1] <= 1'b0;
            else if (adv)
                dv_v_reg[i+1] <= dv_v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                dv_reg[i+1] <= dv_next;
        end
    end

    // apply quotient sign
    logic  tv_v_reg;
    tval_t tv_reg, tv_next;

    always_comb
    begin
        tv_next.o    = dv_reg[TW].ray.o;
        tv_next.d    = dv_reg[TW].ray.d;
        tv_next.tlo  = dv_reg[TW].ray.tlo;
        tv_next.thi  = dv_reg[TW].ray.thi;
        tv_next.t    = dv_reg[TW].neg ? TW'(-$signed(dv_reg[TW].quo)) : dv_reg[TW].quo;
        tv_next.ff   = dv_reg[TW].ff;
        tv_next.miss = dv_reg[TW].miss;
    end

    // partial products of t times each direction component, interval check
    logic mu_v_reg;
    mul_t mu_reg, mu_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mu_next.pph[k] = $signed(tv_reg.t[TW-1:L]) * $signed(tv_reg.d[k]);
            mu_next.ppl[k] = $signed({1'b0, tv_reg.t[L-1:0]}) * $signed(tv_reg.d[k]);
        end
        mu_next.o    = tv_reg.o;
        mu_next.t    = tv_reg.t;
        mu_next.ff   = tv_reg.ff;
        mu_next.miss = tv_reg.miss
                     || ($signed(tv_reg.t) < TW'($signed(tv_reg.tlo)))
                     || ($signed(tv_reg.t) > TW'($signed(tv_reg.thi)));
    end

    // sum partial products, wrapping to the product word
    logic  pr_v_reg;
    prod_t pr_reg, pr_next;
    logic signed [XW-1:0] full [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            full[k] = (XW'($signed(mu_reg.pph[k])) <<< L) + XW'($signed(mu_reg.ppl[k]));
            pr_next.prod[k] = full[k][PW-1:0];
        end
        pr_next.o    = mu_reg.o;
        pr_next.t    = mu_reg.t;
        pr_next.ff   = mu_reg.ff;
        pr_next.miss = mu_reg.miss;
    end

    // hit point: origin plus floor of scaled product
    logic pt_v_reg;
    pnt_t pt_reg, pt_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            pt_next.p[k] = PPW'($signed(pr_reg.prod[k][PW-1:F])) + PPW'($signed(pr_reg.o[k]));
        pt_next.t    = pr_reg.t;
        pt_next.ff   = pr_reg.ff;
        pt_next.miss = pr_reg.miss;
    end

    // span check, saturation and u,v divider setup
    logic              uv_v_reg [0:UW];
    uv_t               uv_reg   [0:UW];
    uv_t               uv0_next;
    logic [PPW-1:0]    pa, pb, xa, xb;
    logic signed [W:0] wa, wb;

    always_comb
    begin
        pa = pt_reg.p[sel.a];
        pb = pt_reg.p[sel.b];
        xa = pa - PPW'($signed(alo_reg));
        xb = pb - PPW'($signed(blo_reg));
        wa = $signed({ahi_reg[W-1], ahi_reg}) - $signed({alo_reg[W-1], alo_reg});
        wb = $signed({bhi_reg[W-1], bhi_reg}) - $signed({blo_reg[W-1], blo_reg});
        uv0_next.tsat = sat_t(pt_reg.t);
        for (int k = 0; k < 3; k++)
            uv0_next.psat[k] = sat_p(pt_reg.p[k]);
        uv0_next.rema = xa[W-1:0];
        uv0_next.wa   = wa[W-1:0];
        uv0_next.qa   = '0;
        uv0_next.remb = xb[W-1:0];
        uv0_next.wb   = wb[W-1:0];
        uv0_next.qb   = '0;
        uv0_next.za   = (wa == '0);
        uv0_next.zb   = (wb == '0);
        uv0_next.ff   = pt_reg.ff;
        uv0_next.miss = pt_reg.miss
                      || ($signed(pa) < PPW'($signed(alo_reg)))
                      || ($signed(pa) > PPW'($signed(ahi_reg)))
                      || ($signed(pb) < PPW'($signed(blo_reg)))
                      || ($signed(pb) > PPW'($signed(bhi_reg)));
    end

    // middle pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_v_reg    <= 1'b0;
            mu_v_reg    <= 1'b0;
            pr_v_reg    <= 1'b0;
            pt_v_reg    <= 1'b0;
            uv_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            tv_v_reg    <= dv_v_reg[TW];
            mu_v_reg    <= tv_v_reg;
            pr_v_reg    <= mu_v_reg;
            pt_v_reg    <= pr_v_reg;
            uv_v_reg[0] <= pt_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tv_reg    <= tv_next;
            mu_reg    <= mu_next;
            pr_reg    <= pr_next;
            pt_reg    <= pt_next;
            uv_reg[0] <= uv0_next;
        end
    end

    // u and v dividers, one quotient bit per stage; the first bit is the 1.0 place
    for (genvar j = 0; j < UW; j++)
    begin : g_uvdiv
        uv_t        uv_next;
        logic [W:0] ra, rb, sa, sb;
        logic       ga, gb;

        always_comb
        begin
            ra = (j == 0) ? {1'b0, uv_reg[j].rema} : {uv_reg[j].rema, 1'b0};
            rb = (j == 0) ? {1'b0, uv_reg[j].remb} : {uv_reg[j].remb, 1'b0};
            sa = ra - {1'b0, uv_reg[j].wa};
            sb = rb - {1'b0, uv_reg[j].wb};
            ga = ra >= {1'b0, uv_reg[j].wa};
            gb = rb >= {1'b0, uv_reg[j].wb};
            uv_next      = uv_reg[j];
            uv_next.rema = ga ? sa[W-1:0] : ra[W-1:0];
            uv_next.remb = gb ? sb[W-1:0] : rb[W-1:0];
            uv_next.qa   = {uv_reg[j].qa[UW-2:0], ga};
            uv_next.qb   = {uv_reg[j].qb[UW-2:0], gb};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                uv_v_reg[j+1] <= 1'b0;
            else if (adv)
                uv_v_reg[j+1] <= uv_v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                uv_reg[j+1] <= uv_next;
        end
    end

    // output register, everything zero on a miss
    logic [ODW-1:0] out_data_reg, out_data_next;
    logic [1:0]     out_user_reg, out_user_next;
    logic [UW-1:0]  u_fin, v_fin;
    logic           hit_fin;

    always_comb
    begin
        hit_fin = !uv_reg[UW].miss;
        u_fin   = uv_reg[UW].za ? '0 : uv_reg[UW].qa;
        v_fin   = uv_reg[UW].zb ? '0 : uv_reg[UW].qb;
        out_data_next = '0;
        out_user_next = '0;
        if (hit_fin)
        begin
            out_data_next = ODW'({v_fin, u_fin, uv_reg[UW].psat[2], uv_reg[UW].psat[1],
                                  uv_reg[UW].psat[0], uv_reg[UW].tsat});
            out_user_next = {uv_reg[UW].ff, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (adv)
            out_v_reg <= uv_v_reg[UW];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // checks
    a_uv_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |->
            (m_tdata[4*W +: UW] <= UW'(ONE_FX)) && (m_tdata[4*W+UW +: UW] <= UW'(ONE_FX)))
        else $error("texture coordinate above one");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
        else $error("miss result carries nonzero fields");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> s0_v_reg)
        else $error("accepted ray did not enter the pipeline");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(uv_v_reg[UW]) && $stable(pt_v_reg))
        else $error("pipeline moved during output stall");

endmodule

`default_nettype wire

/* verif/ray_axis_rect_intersect_top_test.sv */
// testbench for the ray against axis-aligned rectangle intersection block
`default_nettype none

module ray_axis_rect_intersect_top_test;
    import rari_pkg::*;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int LATENCY = CW + 2*FB + 10;
    localparam int HOLD_CYCLES = 400;

    typedef logic signed [CW-1:0] ray_t [8];

    typedef struct {
        logic            hit;
        logic            front;
        logic [CW-1:0]   t;
        logic [CW-1:0]   x;
        logic [CW-1:0]   y;
        logic [CW-1:0]   z;
        logic [FB:0]     u;
        logic [FB:0]     v;
    } hit_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [8*CW-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    // hit_t, hit_x, hit_y, hit_z, tex_u, tex_v, zero fill
    logic [((4*CW+2*FB+2+7)/8)*8-1:0] m_tdata;
    // hit, front_face
    logic [1:0] m_tuser;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CW-1:0] cfg_data;

    // rectangle registers as the block should hold them
    logic [1:0]          rect_axis;
    logic signed [CW-1:0] rect_pos, rect_a_lo, rect_a_hi, rect_b_lo, rect_b_hi;

    hit_result_t expected_hits[$];
    int errors = 0;
    int rays_sent = 0;
    int results_seen = 0;
    int hits_seen = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;

    ray_axis_rect_intersect_top u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #30_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // saturate a wide value to the coordinate range
    function automatic logic [CW-1:0] clamp_coord(input logic signed [127:0] val);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (CW-1)) - 1;
        lo = -hi - 1;
        if (val > hi)
            return hi[CW-1:0];
        if (val < lo)
            return lo[CW-1:0];
        return val[CW-1:0];
    endfunction

    // expected outcome of one ray against the current rectangle
    function automatic hit_result_t predict_hit(input ray_t r);
        hit_result_t res;
        logic signed [127:0] o [3];
        logic signed [127:0] d [3];
        logic signed [127:0] p [3];
        logic signed [127:0] tq, wa, wb, alo, ahi, blo, bhi, tlo, thi;
        int n, a, b;
        res = '{default: '0};
        for (int k = 0; k < 3; k++)
        begin
            o[k] = r[k];
            d[k] = r[3+k];
        end
        tlo = r[6];
        thi = r[7];
        case (axis_t'(rect_axis))
            AXIS_XY: begin n = 2; a = 0; b = 1; end
            AXIS_XZ: begin n = 1; a = 0; b = 2; end
            AXIS_YZ: begin n = 0; a = 1; b = 2; end
            default: return res;
        endcase
        if (d[n] == 0)
            return res;
        tq = ((128'(rect_pos) - o[n]) <<< FB) / d[n];
        if (tq < tlo || tq > thi)
            return res;
        for (int k = 0; k < 3; k++)
            p[k] = o[k] + ((tq * d[k]) >>> FB);
        alo = rect_a_lo;
        ahi = rect_a_hi;
        blo = rect_b_lo;
        bhi = rect_b_hi;
        if (p[a] < alo || p[a] > ahi || p[b] < blo || p[b] > bhi)
            return res;
        wa = ahi - alo;
        wb = bhi - blo;
        if (wa > 0)
            res.u = 17'(((p[a] - alo) <<< FB) / wa);
        if (wb > 0)
            res.v = 17'(((p[b] - blo) <<< FB) / wb);
        res.hit = 1'b1;
        res.t = clamp_coord(tq);
        res.x = clamp_coord(p[0]);
        res.y = clamp_coord(p[1]);
        res.z = clamp_coord(p[2]);
        res.front = (d[n] < 0);
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("error at %0t: %s got %h expected %h", $realtime, field, got, want);
    endtask

    // result checker
    always @(posedge clk)
    begin
        hit_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_hits.size() == 0)
            begin
                report_mismatch("unexpected transaction", 64'(m_tuser), 64'd0);
            end
            else
            begin
                want = expected_hits.pop_front();
                if (want.hit)
                    hits_seen++;
                if (m_tuser[0] !== want.hit)
                    report_mismatch("hit", 64'(m_tuser[0]), 64'(want.hit));
                if (m_tuser[1] !== want.front)
                    report_mismatch("front_face", 64'(m_tuser[1]), 64'(want.front));
                if (m_tdata[31:0] !== want.t)
                    report_mismatch("hit_t", 64'(m_tdata[31:0]), 64'(want.t));
                if (m_tdata[63:32] !== want.x)
                    report_mismatch("hit_x", 64'(m_tdata[63:32]), 64'(want.x));
                if (m_tdata[95:64] !== want.y)
                    report_mismatch("hit_y", 64'(m_tdata[95:64]), 64'(want.y));
                if (m_tdata[127:96] !== want.z)
                    report_mismatch("hit_z", 64'(m_tdata[127:96]), 64'(want.z));
                if (m_tdata[144:128] !== want.u)
                    report_mismatch("tex_u", 64'(m_tdata[144:128]), 64'(want.u));
                if (m_tdata[161:145] !== want.v)
                    report_mismatch("tex_v", 64'(m_tdata[161:145]), 64'(want.v));
            end
        end
    end

    // receiver: random stalls plus requested long hold-offs
    always @(posedge clk)
    begin
        int hold_left;
        int hold_done;
        if (!rst_n)
        begin
            hold_left = 0;
            hold_done = hold_req;
            m_tready <= 1'b0;
        end
        else
        begin
            if (hold_req != hold_done)
            begin
                hold_done = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // send one ray, idling first at the current rate
    task automatic send_ray(input ray_t r);
        logic [8*CW-1:0] ray_bits;
        if ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        for (int i = 0; i < 8; i++)
            ray_bits[CW*i +: CW] = r[i];
        s_tvalid <= 1'b1;
        s_tdata <= ray_bits;
        do
            @(posedge clk);
        while (!s_tready);
        expected_hits.push_back(predict_hit(r));
        rays_sent++;
    endtask

    // wait until the pipeline is empty
    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // one register write; the caller drops cfg_valid after the last one
    task automatic write_reg(input cfg_idx_t idx, input logic [CW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_PLANE_AXIS:  rect_axis = val[1:0];
            CFG_PLANE_POS:   rect_pos = val;
            CFG_SPAN_A_LOW:  rect_a_lo = val;
            CFG_SPAN_A_HIGH: rect_a_hi = val;
            CFG_SPAN_B_LOW:  rect_b_lo = val;
            CFG_SPAN_B_HIGH: rect_b_hi = val;
            default: ;
        endcase
    endtask

    task automatic set_rect(input logic [CW-1:0] axis, input longint pos,
                            input longint alo, input longint ahi,
                            input longint blo, input longint bhi);
        drain();
        write_reg(CFG_PLANE_AXIS, axis);
        write_reg(CFG_PLANE_POS, CW'(pos));
        write_reg(CFG_SPAN_A_LOW, CW'(alo));
        write_reg(CFG_SPAN_A_HIGH, CW'(ahi));
        write_reg(CFG_SPAN_B_LOW, CW'(blo));
        write_reg(CFG_SPAN_B_HIGH, CW'(bhi));
        cfg_valid <= 1'b0;
    endtask

    function automatic longint pick_in_span(input longint lo, input longint hi);
        longint w;
        w = hi - lo;
        if (w < 0)
            return lo;
        return lo + longint'({$urandom, $urandom} % (longint'(w) + 1));
    endfunction

    // rays aimed at the rectangle mostly, fully random the rest
    task automatic send_random(input int count);
        ray_t r;
        longint p [3];
        longint dv [3];
        longint tv;
        int n, a, b;
        for (int i = 0; i < count; i++)
        begin
            case (axis_t'(rect_axis))
                AXIS_XY: begin n = 2; a = 0; b = 1; end
                AXIS_XZ: begin n = 1; a = 0; b = 2; end
                default: begin n = 0; a = 1; b = 2; end
            endcase
            if ($urandom_range(99) < 30)
            begin
                for (int k = 0; k < 8; k++)
                    r[k] = $urandom;
            end
            else
            begin
                p[n] = rect_pos;
                p[a] = pick_in_span(rect_a_lo, rect_a_hi);
                p[b] = pick_in_span(rect_b_lo, rect_b_hi);
                // widen the target a little so the edges are crossed too
                if ($urandom_range(9) == 0)
                    p[a] += longint'($urandom_range(0, 2048)) - 1024;
                tv = $urandom_range(0, 1 << 20);
                for (int k = 0; k < 3; k++)
                begin
                    dv[k] = longint'($urandom_range(0, 1 << 19)) - (1 << 18);
                    r[k] = CW'(p[k] - ((tv * dv[k]) >>> FB));
                    r[3+k] = CW'(dv[k]);
                end
                r[6] = CW'(tv - longint'($urandom_range(0, 1 << 17)) + (1 << 14));
                r[7] = CW'(tv + longint'($urandom_range(0, 1 << 17)) - (1 << 14));
            end
            send_ray(r);
        end
    endtask

    // handmade rays against the unit square in the xy plane
    task automatic test_directed;
        ray_t r;
        localparam logic signed [CW-1:0] ONE = 1 <<< FB;
        localparam logic signed [CW-1:0] HALF = 1 <<< (FB-1);
        localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
        localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};
        // straight down onto the center, front face
        r = '{HALF, HALF, ONE, 0, 0, -ONE, 0, 10*ONE};
        send_ray(r);
        // from below, back face
        r = '{HALF, HALF, -ONE, 0, 0, ONE, 0, 10*ONE};
        send_ray(r);
        // parallel to the plane
        r = '{HALF, HALF, ONE, ONE, 0, 0, MINV, MAXV};
        send_ray(r);
        // t beyond the upper bound, then exactly at both bounds
        r = '{HALF, HALF, 2*ONE, 0, 0, -ONE, 0, ONE};
        send_ray(r);
        r = '{HALF, HALF, 2*ONE, 0, 0, -ONE, 2*ONE, 2*ONE};
        send_ray(r);
        // t below the lower bound (behind the origin)
        r = '{HALF, HALF, -ONE, 0, 0, -ONE, 0, MAXV};
        send_ray(r);
        // corners of the square, inclusive
        r = '{ONE, ONE, ONE, 0, 0, -ONE, 0, MAXV};
        send_ray(r);
        r = '{0, 0, ONE, 0, 0, -ONE, 0, MAXV};
        send_ray(r);
        // just outside each span
        r = '{ONE + 1, HALF, ONE, 0, 0, -ONE, 0, MAXV};
        send_ray(r);
        r = '{HALF, -1, ONE, 0, 0, -ONE, 0, MAXV};
        send_ray(r);
        // slanted ray, fractional point and texture
        r = '{0, 0, ONE, HALF, HALF >>> 1, -ONE, MINV, MAXV};
        send_ray(r);
        // extremes of every field
        r = '{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV};
        send_ray(r);
        r = '{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV};
        send_ray(r);
        r = '{0, 0, MAXV, 0, 0, 1, MINV, MAXV};
        send_ray(r);
        r = '{0, 0, MINV, 0, 0, -1, MINV, MAXV};
        send_ray(r);
        r = '{HALF, HALF, MAXV, 0, 0, MINV, MINV, MAXV};
        send_ray(r);
        r = '{-1, -1, -1, -1, -1, -1, -1, -1};
        send_ray(r);
        // huge t saturates the point
        r = '{MAXV, MINV, ONE, MAXV, MINV, -1, MINV, MAXV};
        send_ray(r);
    endtask

    // each orientation under each idling pattern
    task automatic test_orientations;
        int idle_set [4] = '{0, 64, 0, 19};
        int stall_set [4] = '{0, 0, 64, 19};
        for (int ax = 0; ax < 3; ax++)
        begin
            set_rect(ax, longint'($urandom_range(0, 1 << 19)) - (1 << 18),
                     -longint'($urandom_range(0, 1 << 19)), $urandom_range(0, 1 << 19),
                     -longint'($urandom_range(0, 1 << 19)), $urandom_range(0, 1 << 19));
            for (int ph = 0; ph < 4; ph++)
            begin
                idle_pct = idle_set[ph];
                stall_pct = stall_set[ph];
                send_random(38);
            end
        end
        idle_pct = 19;
        stall_pct = 19;
    endtask

    // no rectangle, empty span and zero-width span
    task automatic test_special_rects;
        set_rect(AXIS_NONE, 0, 0, 1 << FB, 0, 1 << FB);
        send_random(60);
        set_rect(AXIS_XZ, 1 << FB, 1 << FB, 0, 0, 1 << FB);
        send_random(60);
        set_rect(AXIS_YZ, -(1 << FB), 3 << FB, 3 << FB, -(2 << FB), 2 << FB);
        send_random(60);
    endtask

    // register extremes
    task automatic test_extreme_rects;
        set_rect(AXIS_XY, 64'sh7fffffff, -64'sh80000000, 64'sh7fffffff,
                 -64'sh80000000, 64'sh7fffffff);
        send_random(60);
        set_rect(AXIS_YZ, -64'sh80000000, -64'sh80000000, 64'sh7fffffff,
                 -64'sh80000000, 64'sh7fffffff);
        send_random(60);
    endtask

    // long receiver hold-off so the pipeline fills and stalls its input
    task automatic test_backpressure;
        set_rect(AXIS_XY, 0, -(2 << FB), 2 << FB, -(2 << FB), 2 << FB);
        idle_pct = 0;
        stall_pct = 0;
        hold_req++;
        send_random(150);
        idle_pct = 19;
        stall_pct = 19;
        send_random(50);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_PLANE_AXIS;
        cfg_data <= '0;
        rect_axis = AXIS_XY;
        rect_pos = 0;
        rect_a_lo = 0;
        rect_a_hi = 1 <<< FB;
        rect_b_lo = 0;
        rect_b_hi = 1 <<< FB;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_orientations();
        test_special_rects();
        test_extreme_rects();
        test_backpressure();
        drain();

        $display("covered %0d rays, %0d results, %0d hits", rays_sent, results_seen,
                 hits_seen);
        $display("orientations, special rectangles, register extremes, stalls, hold-off");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
